[hdl/dtp_pkg.sv]
// shared types and constants for the disparity to point reprojection block
package dtp_pkg;

    // field and register widths
    localparam int PIX_W       = 12;
    localparam int COORD_MAX_W = 16;
    localparam int DISP_W      = 16;
    localparam int CFG_W       = 32;
    localparam int OUT_W       = 48;
    localparam int IDX_W       = 3;

    // divider geometry: quotient bits, divisor width (2 * |d|)
    localparam int QUOT_W = OUT_W;
    localparam int DEN_W  = DISP_W + 1;

    // numerator scaling: drop 19 fraction bits, z numerator is w << 5
    localparam int ROUND_SHIFT = 19;
    localparam int Z_SHIFT     = 5;
    // divider numerator width is COORD_BITS plus this
    localparam int NUM_W_BASE  = 47;

    // register reset values
    localparam logic [CFG_W-1:0] INV_ONE = 32'h0100_0000;

    // saturation limits
    localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_FOCAL_BASELINE = 3'd0,
        REG_INV_ROW0_COL0  = 3'd1,
        REG_INV_ROW0_COL1  = 3'd2,
        REG_INV_ROW0_COL2  = 3'd3,
        REG_INV_ROW1_COL1  = 3'd4,
        REG_INV_ROW1_COL2  = 3'd5
    } reg_index_t;

    // input item
    typedef struct packed {
        logic [PIX_W-1:0]         pixel_col;
        logic [PIX_W-1:0]         pixel_row;
        logic signed [DISP_W-1:0] disparity;
    } pixel_t;

    // result item
    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic signed [OUT_W-1:0] point_z;
        logic                    point_valid;
    } point_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0]        focal_baseline;
        logic signed [CFG_W-1:0] inv_row0_col0;
        logic signed [CFG_W-1:0] inv_row0_col1;
        logic signed [CFG_W-1:0] inv_row0_col2;
        logic signed [CFG_W-1:0] inv_row1_col1;
        logic signed [CFG_W-1:0] inv_row1_col2;
    } cfg_t;

    // per-lane control traveling with the data
    typedef struct packed {
        logic valid;
        logic neg;
        logic nomatch;
    } lane_ctl_t;

endpackage

[hdl/dtp_front.sv]
// front pipeline: intrinsic transform, scaling by w and divider operand setup
module dtp_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  dtp_pkg::pixel_t                     pixel,
    input  dtp_pkg::cfg_t                       cfg,
    output logic [COORD_BITS+dtp_pkg::NUM_W_BASE-1:0] num_x,
    output logic [COORD_BITS+dtp_pkg::NUM_W_BASE-1:0] num_y,
    output logic [COORD_BITS+dtp_pkg::NUM_W_BASE-1:0] num_z,
    output logic [dtp_pkg::DEN_W-1:0]           den,
    output dtp_pkg::lane_ctl_t                  ctl_x,
    output dtp_pkg::lane_ctl_t                  ctl_y,
    output dtp_pkg::lane_ctl_t                  ctl_z
);

    localparam int PROD_W = 33 + COORD_BITS;
    localparam int PX_W   = 34 + COORD_BITS;
    localparam int MAG_W  = 33 + COORD_BITS;
    localparam int LO_W   = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = LO_W + dtp_pkg::CFG_W;
    localparam int PHI_W  = HI_W + dtp_pkg::CFG_W;
    localparam int N_W    = MAG_W + dtp_pkg::CFG_W;
    localparam int M_W    = COORD_BITS + dtp_pkg::NUM_W_BASE;
    localparam int DW     = dtp_pkg::DISP_W;

    // stage 1: input capture
    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] s1_x_reg, s1_x_next;
    logic [COORD_BITS-1:0] s1_y_reg, s1_y_next;
    logic signed [DW-1:0]  s1_d_reg;
    logic [dtp_pkg::COORD_MAX_W-1:0] col_ext, row_ext;

    // stage 2: products and disparity magnitude
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_p00_reg, s2_p00_next;
    logic signed [PROD_W-1:0] s2_p01_reg, s2_p01_next;
    logic signed [PROD_W-1:0] s2_p11_reg, s2_p11_next;
    logic [DW-1:0]            s2_dm_reg, s2_dm_next;
    logic                     s2_dneg_reg, s2_dzero_reg;

    // stage 3: sums
    logic                   s3_valid_reg;
    logic signed [PX_W-1:0] s3_px_reg, s3_px_next;
    logic signed [PX_W-1:0] s3_py_reg, s3_py_next;
    logic [DW-1:0]          s3_dm_reg;
    logic                   s3_dneg_reg, s3_dzero_reg;

    // stage 4: sign and magnitude
    logic             s4_valid_reg;
    logic [MAG_W-1:0] s4_xmag_reg, s4_xmag_next;
    logic [MAG_W-1:0] s4_ymag_reg, s4_ymag_next;
    logic             s4_xneg_reg, s4_xneg_next;
    logic             s4_yneg_reg, s4_yneg_next;
    logic [DW-1:0]    s4_dm_reg;
    logic             s4_dneg_reg, s4_dzero_reg;

    // stage 5: partial products with w
    logic             s5_valid_reg;
    logic [PLO_W-1:0] s5_xlo_reg, s5_xlo_next;
    logic [PHI_W-1:0] s5_xhi_reg, s5_xhi_next;
    logic [PLO_W-1:0] s5_ylo_reg, s5_ylo_next;
    logic [PHI_W-1:0] s5_yhi_reg, s5_yhi_next;
    logic [DW-1:0]    s5_dm_reg;
    logic             s5_xneg_reg, s5_yneg_reg, s5_dneg_reg, s5_dzero_reg;

    // stage 6: full numerators
    logic           s6_valid_reg;
    logic [N_W-1:0] s6_nx_reg, s6_nx_next;
    logic [N_W-1:0] s6_ny_reg, s6_ny_next;
    logic [DW-1:0]  s6_dm_reg;
    logic           s6_xneg_reg, s6_yneg_reg, s6_dneg_reg, s6_dzero_reg;

    // stage 7: divider operands with rounding offset
    logic                      s7_valid_reg;
    logic [M_W-1:0]            s7_mx_reg, s7_mx_next;
    logic [M_W-1:0]            s7_my_reg, s7_my_next;
    logic [M_W-1:0]            s7_mz_reg, s7_mz_next;
    logic [dtp_pkg::DEN_W-1:0] s7_den_reg, s7_den_next;
    logic                      s7_xneg_reg, s7_yneg_reg, s7_dneg_reg, s7_dzero_reg;

    // coordinate masking to COORD_BITS
    always_comb
    begin
        col_ext   = dtp_pkg::COORD_MAX_W'(pixel.pixel_col);
        row_ext   = dtp_pkg::COORD_MAX_W'(pixel.pixel_row);
        s1_x_next = col_ext[COORD_BITS-1:0];
        s1_y_next = row_ext[COORD_BITS-1:0];
    end

    // intrinsic products and disparity magnitude
    always_comb
    begin
        s2_p00_next = PROD_W'(cfg.inv_row0_col0) * PROD_W'($signed({1'b0, s1_x_reg}));
        s2_p01_next = PROD_W'(cfg.inv_row0_col1) * PROD_W'($signed({1'b0, s1_y_reg}));
        s2_p11_next = PROD_W'(cfg.inv_row1_col1) * PROD_W'($signed({1'b0, s1_y_reg}));
        s2_dm_next  = s1_d_reg[DW-1] ? DW'(-s1_d_reg) : DW'(s1_d_reg);
    end

    // transformed coordinates in Q.24
    always_comb
    begin
        s3_px_next = PX_W'(s2_p00_reg) + PX_W'(s2_p01_reg) + PX_W'(cfg.inv_row0_col2);
        s3_py_next = PX_W'(s2_p11_reg) + PX_W'(cfg.inv_row1_col2);
    end

    // magnitudes and result signs
    always_comb
    begin
        s4_xmag_next = s3_px_reg[PX_W-1] ? MAG_W'(-s3_px_reg) : MAG_W'(s3_px_reg);
        s4_ymag_next = s3_py_reg[PX_W-1] ? MAG_W'(-s3_py_reg) : MAG_W'(s3_py_reg);
        s4_xneg_next = s3_px_reg[PX_W-1] ^ s3_dneg_reg;
        s4_yneg_next = s3_py_reg[PX_W-1] ^ s3_dneg_reg;
    end

    // split multiply of magnitude by w
    always_comb
    begin
        s5_xlo_next = PLO_W'(s4_xmag_reg[LO_W-1:0]) * PLO_W'(cfg.focal_baseline);
        s5_xhi_next = PHI_W'(s4_xmag_reg[MAG_W-1:LO_W]) * PHI_W'(cfg.focal_baseline);
        s5_ylo_next = PLO_W'(s4_ymag_reg[LO_W-1:0]) * PLO_W'(cfg.focal_baseline);
        s5_yhi_next = PHI_W'(s4_ymag_reg[MAG_W-1:LO_W]) * PHI_W'(cfg.focal_baseline);
    end

    // recombine partial products
    always_comb
    begin
        s6_nx_next = N_W'(s5_xlo_reg) + (N_W'(s5_xhi_reg) << LO_W);
        s6_ny_next = N_W'(s5_ylo_reg) + (N_W'(s5_yhi_reg) << LO_W);
    end

    // fold 2^19 * |d| rounding offset in, divisor is 2 * |d|
    always_comb
    begin
        s7_mx_next  = M_W'(s6_nx_reg >> dtp_pkg::ROUND_SHIFT) + M_W'(s6_dm_reg);
        s7_my_next  = M_W'(s6_ny_reg >> dtp_pkg::ROUND_SHIFT) + M_W'(s6_dm_reg);
        s7_mz_next  = (M_W'(cfg.focal_baseline) << dtp_pkg::Z_SHIFT) + M_W'(s6_dm_reg);
        s7_den_next = {s6_dm_reg, 1'b0};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        s1_x_reg     <= s1_x_next;
        s1_y_reg     <= s1_y_next;
        s1_d_reg     <= pixel.disparity;

        s2_p00_reg   <= s2_p00_next;
        s2_p01_reg   <= s2_p01_next;
        s2_p11_reg   <= s2_p11_next;
        s2_dm_reg    <= s2_dm_next;
        s2_dneg_reg  <= s1_d_reg[DW-1];
        s2_dzero_reg <= (s1_d_reg == '0);

        s3_px_reg    <= s3_px_next;
        s3_py_reg    <= s3_py_next;
        s3_dm_reg    <= s2_dm_reg;
        s3_dneg_reg  <= s2_dneg_reg;
        s3_dzero_reg <= s2_dzero_reg;

        s4_xmag_reg  <= s4_xmag_next;
        s4_ymag_reg  <= s4_ymag_next;
        s4_xneg_reg  <= s4_xneg_next;
        s4_yneg_reg  <= s4_yneg_next;
        s4_dm_reg    <= s3_dm_reg;
        s4_dneg_reg  <= s3_dneg_reg;
        s4_dzero_reg <= s3_dzero_reg;

        s5_xlo_reg   <= s5_xlo_next;
        s5_xhi_reg   <= s5_xhi_next;
        s5_ylo_reg   <= s5_ylo_next;
        s5_yhi_reg   <= s5_yhi_next;
        s5_dm_reg    <= s4_dm_reg;
        s5_xneg_reg  <= s4_xneg_reg;
        s5_yneg_reg  <= s4_yneg_reg;
        s5_dneg_reg  <= s4_dneg_reg;
        s5_dzero_reg <= s4_dzero_reg;

        s6_nx_reg    <= s6_nx_next;
        s6_ny_reg    <= s6_ny_next;
        s6_dm_reg    <= s5_dm_reg;
        s6_xneg_reg  <= s5_xneg_reg;
        s6_yneg_reg  <= s5_yneg_reg;
        s6_dneg_reg  <= s5_dneg_reg;
        s6_dzero_reg <= s5_dzero_reg;

        s7_mx_reg    <= s7_mx_next;
        s7_my_reg    <= s7_my_next;
        s7_mz_reg    <= s7_mz_next;
        s7_den_reg   <= s7_den_next;
        s7_xneg_reg  <= s6_xneg_reg;
        s7_yneg_reg  <= s6_yneg_reg;
        s7_dneg_reg  <= s6_dneg_reg;
        s7_dzero_reg <= s6_dzero_reg;
    end

    // outputs to the dividers
    assign num_x = s7_mx_reg;
    assign num_y = s7_my_reg;
    assign num_z = s7_mz_reg;
    assign den   = s7_den_reg;

    always_comb
    begin
        ctl_x.valid   = s7_valid_reg;
        ctl_x.neg     = s7_xneg_reg;
        ctl_x.nomatch = s7_dzero_reg;
        ctl_y.valid   = s7_valid_reg;
        ctl_y.neg     = s7_yneg_reg;
        ctl_y.nomatch = s7_dzero_reg;
        ctl_z.valid   = s7_valid_reg;
        ctl_z.neg     = s7_dneg_reg;
        ctl_z.nomatch = s7_dzero_reg;
    end

endmodule

[hdl/dtp_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow detect
module dtp_div #(
    parameter int NUM_W = 59
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [NUM_W-1:0]          num,
    input  logic [dtp_pkg::DEN_W-1:0] den,
    input  dtp_pkg::lane_ctl_t        ctl_in,
    output logic [dtp_pkg::QUOT_W-1:0] quot,
    output logic                      ovf,
    output dtp_pkg::lane_ctl_t        ctl_out
);

    localparam int QW    = dtp_pkg::QUOT_W;
    localparam int DW    = dtp_pkg::DEN_W;
    localparam int TOP_W = NUM_W - QW;
    localparam int CMP_W = (TOP_W > DW) ? TOP_W : DW;

    // stage 0 is the overflow check, stages 1..QW produce one quotient bit each
    dtp_pkg::lane_ctl_t ctl_reg  [0:QW];
    logic [DW-1:0]      rem_reg  [0:QW];
    logic [QW-1:0]      work_reg [0:QW];
    logic [DW-1:0]      den_reg  [0:QW];
    logic               ovf_reg  [0:QW];

    logic [TOP_W-1:0] top;
    logic             ovf_next;
    logic [DW-1:0]    rem0_next;

    // quotient overflows 48 bits when the high numerator part reaches the divisor
    always_comb
    begin
        top       = num[NUM_W-1:QW];
        ovf_next  = CMP_W'(top) >= CMP_W'(den);
        rem0_next = ovf_next ? '0 : DW'(top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem0_next;
        work_reg[0] <= num[QW-1:0];
        den_reg[0]  <= den;
        ovf_reg[0]  <= ovf_next;
    end

    // compare-subtract stages
    for (genvar i = 1; i <= QW; i++)
    begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[i-1], work_reg[i-1][QW-1]};
            ge       = trial >= {1'b0, den_reg[i-1]};
            rem_next = ge ? DW'(trial - {1'b0, den_reg[i-1]}) : trial[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= rem_next;
            work_reg[i] <= {work_reg[i-1][QW-2:0], ge};
            den_reg[i]  <= den_reg[i-1];
            ovf_reg[i]  <= ovf_reg[i-1];
        end
    end

    assign quot    = work_reg[QW];
    assign ovf     = ovf_reg[QW];
    assign ctl_out = ctl_reg[QW];

endmodule

[hdl/disparity_to_point_reprojection.sv]
// top level: register file, front pipeline, three dividers and result stage
//
// Reprojects one pixel (column, row, signed Q12.4 disparity) to a 3D point in
// signed Q32.16, rounded to nearest and saturated to 48 bits.
// Input channel: an item is taken at each rising edge with start high and
// busy low. busy is always low, so a new item may be given every cycle.
// Result channel: done is high for one cycle with the point on the point
// port; the receiver takes it in that cycle and cannot hold it off.
// The path from the accepting edge to the result runs through 7 front stages
// (input capture, products, sums, magnitudes, split multiply by w, recombine,
// rounding offset), 49 divider stages (overflow check plus one quotient bit
// per stage over 48 bits) and one output register.
// Throughput is one item per cycle; every stage advances every cycle.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once,
// indexes beyond the list are ignored; write only while no item is in flight.
// Reset clears all valid bits, sets w to 0 and the inverse intrinsic to the
// identity; items in flight at reset are dropped.
module disparity_to_point_reprojection #(
    parameter int COORD_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  dtp_pkg::pixel_t            pixel,
    output logic                       done,
    output dtp_pkg::point_t            point,
    input  logic                       cfg_we,
    input  logic [dtp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [dtp_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int M_W = COORD_BITS + dtp_pkg::NUM_W_BASE;
    localparam int QW  = dtp_pkg::QUOT_W;

    dtp_pkg::cfg_t cfg_reg;

    logic [M_W-1:0]            num_x, num_y, num_z;
    logic [dtp_pkg::DEN_W-1:0] den;
    dtp_pkg::lane_ctl_t        fctl_x, fctl_y, fctl_z;
    dtp_pkg::lane_ctl_t        dctl_x, dctl_y, dctl_z;
    logic [QW-1:0]             quot_x, quot_y, quot_z;
    logic                      ovf_x, ovf_y, ovf_z;

    logic           done_reg;
    dtp_pkg::point_t point_reg, point_next;

    // sign, saturation and no-match handling of one lane
    function automatic logic [QW-1:0] finish_lane(
        input logic [QW-1:0] q,
        input logic          q_ovf,
        input logic          neg,
        input logic          nomatch
    );
        logic [QW-1:0] r;
        if (nomatch)
        begin
            r = '0;
        end
        else if (!neg)
        begin
            r = (q_ovf || q[QW-1]) ? dtp_pkg::POS_MAX : q;
        end
        else
        begin
            r = (q_ovf || (q[QW-1] && (|q[QW-2:0]))) ? dtp_pkg::NEG_MIN : QW'(-q);
        end
        return r;
    endfunction

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_baseline <= '0;
            cfg_reg.inv_row0_col0  <= dtp_pkg::INV_ONE;
            cfg_reg.inv_row0_col1  <= '0;
            cfg_reg.inv_row0_col2  <= '0;
            cfg_reg.inv_row1_col1  <= dtp_pkg::INV_ONE;
            cfg_reg.inv_row1_col2  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dtp_pkg::REG_FOCAL_BASELINE: cfg_reg.focal_baseline <= cfg_wdata;
                dtp_pkg::REG_INV_ROW0_COL0:  cfg_reg.inv_row0_col0  <= cfg_wdata;
                dtp_pkg::REG_INV_ROW0_COL1:  cfg_reg.inv_row0_col1  <= cfg_wdata;
                dtp_pkg::REG_INV_ROW0_COL2:  cfg_reg.inv_row0_col2  <= cfg_wdata;
                dtp_pkg::REG_INV_ROW1_COL1:  cfg_reg.inv_row1_col1  <= cfg_wdata;
                dtp_pkg::REG_INV_ROW1_COL2:  cfg_reg.inv_row1_col2  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // the pipeline never stalls
    assign busy = 1'b0;

    dtp_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .pixel (pixel),
        .cfg   (cfg_reg),
        .num_x (num_x),
        .num_y (num_y),
        .num_z (num_z),
        .den   (den),
        .ctl_x (fctl_x),
        .ctl_y (fctl_y),
        .ctl_z (fctl_z)
    );

    dtp_div #(
        .NUM_W(M_W)
    ) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .num     (num_x),
        .den     (den),
        .ctl_in  (fctl_x),
        .quot    (quot_x),
        .ovf     (ovf_x),
        .ctl_out (dctl_x)
    );

    dtp_div #(
        .NUM_W(M_W)
    ) u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .num     (num_y),
        .den     (den),
        .ctl_in  (fctl_y),
        .quot    (quot_y),
        .ovf     (ovf_y),
        .ctl_out (dctl_y)
    );

    dtp_div #(
        .NUM_W(M_W)
    ) u_div_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .num     (num_z),
        .den     (den),
        .ctl_in  (fctl_z),
        .quot    (quot_z),
        .ovf     (ovf_z),
        .ctl_out (dctl_z)
    );

    // result assembly
    always_comb
    begin
        point_next.point_x     = finish_lane(quot_x, ovf_x, dctl_x.neg, dctl_x.nomatch);
        point_next.point_y     = finish_lane(quot_y, ovf_y, dctl_y.neg, dctl_y.nomatch);
        point_next.point_z     = finish_lane(quot_z, ovf_z, dctl_z.neg, dctl_z.nomatch);
        point_next.point_valid = !dctl_x.nomatch;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dctl_x.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign done  = done_reg;
    assign point = point_reg;

endmodule

[sim/testbench.sv]
// self-checking testbench for the disparity to point reprojection block
module testbench;

    localparam int COORD_BITS  = 12;
    localparam int LATENCY     = 57;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 7;
    localparam int RAND_ITEMS  = 250;

    // indexes past the register list, writes there must be ignored
    localparam logic [dtp_pkg::IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [dtp_pkg::IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic start = 1'b0;
    logic busy;
    dtp_pkg::pixel_t pixel_in = '0;
    logic done;
    dtp_pkg::point_t point_out;
    logic cfg_we;
    logic [dtp_pkg::IDX_W-1:0] cfg_index;
    logic [dtp_pkg::CFG_W-1:0] cfg_wdata;

    // pixels waiting to be sent, points waiting to come back
    dtp_pkg::pixel_t pending_pixels[$];
    dtp_pkg::point_t expected_points[$];
    dtp_pkg::point_t oldest_point;

    // shadow copy of the calibration registers
    dtp_pkg::cfg_t cal;

    int idle_pct = 0;
    int cycle_count = 0;
    int errors = 0;
    int items_accepted = 0;
    int points_checked = 0;
    int phases_run = 0;

    disparity_to_point_reprojection #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel_in),
        .done(done),
        .point(point_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    // p * w / (d * 2^20) on magnitudes, rounded half away from zero, saturated
    function automatic logic [dtp_pkg::OUT_W-1:0] scale_coord(longint p,
                                                              logic [dtp_pkg::CFG_W-1:0] w,
                                                              longint d);
        logic neg;
        logic [127:0] mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] r;
        neg = (p < 0) != (d < 0);
        mag = (p < 0) ? 128'(-p) : 128'(p);
        num = mag * {96'd0, w};
        den = 128'((d < 0) ? -d : d) << 20;
        q = num / den;
        r = num % den;
        if ((r << 1) >= den)
            q = q + 1;
        if (q == 0)
            return '0;
        if (!neg)
            return (q > 128'(dtp_pkg::POS_MAX)) ? dtp_pkg::POS_MAX : q[dtp_pkg::OUT_W-1:0];
        if (q > 128'(dtp_pkg::NEG_MIN))
            q = 128'(dtp_pkg::NEG_MIN);
        q = -q;
        return q[dtp_pkg::OUT_W-1:0];
    endfunction

    // expected 3d point for one pixel under the shadow calibration
    function automatic dtp_pkg::point_t reproject_pixel(dtp_pkg::pixel_t pix);
        dtp_pkg::point_t pt;
        longint x;
        longint y;
        longint d;
        longint px;
        longint py;
        pt = '0;
        x = longint'(pix.pixel_col[COORD_BITS-1:0]);
        y = longint'(pix.pixel_row[COORD_BITS-1:0]);
        d = longint'(pix.disparity);
        if (d != 0)
        begin
            px = longint'(cal.inv_row0_col0) * x + longint'(cal.inv_row0_col1) * y
                 + longint'(cal.inv_row0_col2);
            py = longint'(cal.inv_row1_col1) * y + longint'(cal.inv_row1_col2);
            pt.point_x = scale_coord(px, cal.focal_baseline, d);
            pt.point_y = scale_coord(py, cal.focal_baseline, d);
            pt.point_z = scale_coord(longint'(1) << 24, cal.focal_baseline, d);
            pt.point_valid = 1'b1;
        end
        return pt;
    endfunction

    // driver: keep start high while pixels are queued, random gaps by idle_pct
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_points.push_back(reproject_pixel(pixel_in));
                items_accepted++;
            end
            if (!start || !busy)
            begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    pixel_in <= pending_pixels.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [dtp_pkg::OUT_W-1:0] want,
                               input logic [dtp_pkg::OUT_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // monitor: every strobed point against the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_points.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected point: expected none, got %h", $time,
                         point_out);
            end
            else
            begin
                oldest_point = expected_points.pop_front();
                check_field("point_x", oldest_point.point_x, point_out.point_x);
                check_field("point_y", oldest_point.point_y, point_out.point_y);
                check_field("point_z", oldest_point.point_z, point_out.point_z);
                check_field("point_valid", dtp_pkg::OUT_W'(oldest_point.point_valid),
                            dtp_pkg::OUT_W'(point_out.point_valid));
                points_checked++;
            end
        end
    end

    // one register write, shadow copy follows
    task automatic write_reg(input logic [dtp_pkg::IDX_W-1:0] idx,
                             input logic [dtp_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dtp_pkg::REG_FOCAL_BASELINE: cal.focal_baseline = value;
            dtp_pkg::REG_INV_ROW0_COL0:  cal.inv_row0_col0 = value;
            dtp_pkg::REG_INV_ROW0_COL1:  cal.inv_row0_col1 = value;
            dtp_pkg::REG_INV_ROW0_COL2:  cal.inv_row0_col2 = value;
            dtp_pkg::REG_INV_ROW1_COL1:  cal.inv_row1_col1 = value;
            dtp_pkg::REG_INV_ROW1_COL2:  cal.inv_row1_col2 = value;
            default: ;
        endcase
    endtask

    task automatic load_calibration(input dtp_pkg::cfg_t c);
        write_reg(dtp_pkg::REG_FOCAL_BASELINE, c.focal_baseline);
        write_reg(dtp_pkg::REG_INV_ROW0_COL0, c.inv_row0_col0);
        write_reg(dtp_pkg::REG_INV_ROW0_COL1, c.inv_row0_col1);
        write_reg(dtp_pkg::REG_INV_ROW0_COL2, c.inv_row0_col2);
        write_reg(dtp_pkg::REG_INV_ROW1_COL1, c.inv_row1_col1);
        write_reg(dtp_pkg::REG_INV_ROW1_COL2, c.inv_row1_col2);
    endtask

    task automatic add_pixel(input int col, input int row, input int disp);
        dtp_pkg::pixel_t pix;
        pix.pixel_col = dtp_pkg::PIX_W'(col);
        pix.pixel_row = dtp_pkg::PIX_W'(row);
        pix.disparity = dtp_pkg::DISP_W'(disp);
        pending_pixels.push_back(pix);
    endtask

    // sender holds off until every queued pixel has come back as a point
    task automatic wait_drained;
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || start || expected_points.size() != 0);
        phases_run++;
    endtask

    // register value: extremes, raw random or a plausible calibration value
    function automatic logic [dtp_pkg::CFG_W-1:0] rand_reg(input bit is_baseline);
        logic [dtp_pkg::CFG_W-1:0] v;
        case ($urandom_range(3))
            0:
            begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = dtp_pkg::INV_ONE;
                endcase
            end
            1: v = $urandom();
            default:
            begin
                if (is_baseline)
                    v = $urandom_range(32'h0100_0000);
                else
                    v = 32'($urandom_range(32'h0400_0000)) - 32'h0200_0000;
            end
        endcase
        return v;
    endfunction

    // random pixel: mostly realistic disparities, some raw, some no match
    task automatic add_random_pixel;
        int disp;
        case ($urandom_range(9))
            0: disp = 0;
            1, 2, 3: disp = $urandom_range(16'hFFFF);
            4: disp = -$urandom_range(1, 2048);
            default: disp = $urandom_range(1, 2048);
        endcase
        add_pixel($urandom_range(4095), $urandom_range(4095), disp);
    endtask

    // main sequence
    initial
    begin
        dtp_pkg::cfg_t c;
        int idle_modes[3];
        idle_modes = '{0, 49, 14};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cal.focal_baseline = '0;
        cal.inv_row0_col0 = dtp_pkg::INV_ONE;
        cal.inv_row0_col1 = '0;
        cal.inv_row0_col2 = '0;
        cal.inv_row1_col1 = dtp_pkg::INV_ONE;
        cal.inv_row1_col2 = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset calibration, zero baseline; unused indexes must change nothing
        write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED_HI, 32'h1234_5678);
        add_pixel(0, 0, 0);
        add_pixel(4095, 4095, 1);
        add_pixel(0, 0, -1);
        add_pixel(4095, 0, 32767);
        add_pixel(0, 4095, -32768);
        wait_drained();

        // unit baseline so that half-way quotients show the rounding
        c = cal;
        c.focal_baseline = 32'd1;
        load_calibration(c);
        add_pixel(1, 1, 32);
        add_pixel(1, 1, -32);
        add_pixel(3, 5, -96);
        add_pixel(2048, 1, 3);
        add_pixel(4095, 4095, 16);
        wait_drained();

        // largest magnitudes: positive and negative saturation
        c.focal_baseline = 32'hFFFF_FFFF;
        c.inv_row0_col0 = 32'h7FFF_FFFF;
        c.inv_row0_col1 = 32'h8000_0000;
        c.inv_row0_col2 = 32'h7FFF_FFFF;
        c.inv_row1_col1 = 32'h8000_0000;
        c.inv_row1_col2 = 32'h8000_0000;
        load_calibration(c);
        add_pixel(4095, 0, 1);
        add_pixel(0, 4095, 1);
        add_pixel(4095, 4095, -1);
        add_pixel(0, 0, 32767);
        add_pixel(4095, 4095, -32768);
        add_pixel(0, 0, 0);
        add_pixel(1, 2, -1);
        wait_drained();

        // unit baseline in q16.16 with one negative diagonal entry and skew
        c.focal_baseline = 32'h0001_0000;
        c.inv_row0_col0 = 32'h8000_0000;
        c.inv_row0_col1 = 32'hFFFF_FFFF;
        c.inv_row0_col2 = 32'h0000_0000;
        c.inv_row1_col1 = 32'h7FFF_FFFF;
        c.inv_row1_col2 = 32'hFFFF_FFFF;
        load_calibration(c);
        add_pixel(4095, 4095, 16);
        add_pixel(2730, 1365, -16);
        add_pixel(1365, 2730, 5);
        add_pixel(0, 0, 21845);
        wait_drained();

        // random calibrations and pixels, sender gaps rotate per phase
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            c.focal_baseline = rand_reg(1'b1);
            c.inv_row0_col0 = rand_reg(1'b0);
            c.inv_row0_col1 = rand_reg(1'b0);
            c.inv_row0_col2 = rand_reg(1'b0);
            c.inv_row1_col1 = rand_reg(1'b0);
            c.inv_row1_col2 = rand_reg(1'b0);
            load_calibration(c);
            idle_pct = idle_modes[ph % 3];
            for (int i = 0; i < RAND_ITEMS; i++)
                add_random_pixel();
            wait_drained();
        end

        // let any stray strobe show up before the verdict
        repeat (LATENCY + 8) @(posedge clk);
        if (expected_points.size() != 0)
        begin
            errors++;
            $display("%0t: %0d points never arrived", $time, expected_points.size());
        end

        $display("%0d pixels sent in %0d phases, %0d points checked, %0d errors",
                 items_accepted, phases_run, points_checked, errors);
        $display("covered reset, rounding, saturation and random calibrations, gaps 0/14/49%%");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hdl/dtp_pkg.sv
hdl/dtp_front.sv
hdl/dtp_div.sv
hdl/disparity_to_point_reprojection.sv
sim/testbench.sv
